// ===== rtl/core/llca_pkg.sv =====
// Shared types, codes and constants of the life-like cellular automaton block.
package llca_pkg;

  // Default grid capacity.
  localparam int MAX_ROWS_DEFAULT = 64;
  localparam int MAX_COLS_DEFAULT = 64;

  // Field and register widths.
  localparam int CMD_W       = 2;
  localparam int ROW_W       = 6;
  localparam int COL_W       = 6;
  localparam int MASK_W      = 9;
  localparam int DIM_W       = 7;
  localparam int COUNT_W     = 4;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 9;

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_WRITE   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_READ    = 2'd1;
  localparam logic [CMD_W-1:0] CMD_ADVANCE = 2'd2;

  // Register indexes.
  localparam logic [CFG_INDEX_W-1:0] REG_SURVIVE = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_BIRTH   = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_ROWS    = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_COLS    = 3'd3;

  // Register reset values.
  localparam logic [MASK_W-1:0] SURVIVE_RESET = 9'd12;
  localparam logic [MASK_W-1:0] BIRTH_RESET   = 9'd12;
  localparam logic [DIM_W-1:0]  ROWS_RESET    = 7'd20;
  localparam logic [DIM_W-1:0]  COLS_RESET    = 7'd40;

  // Survive and birth masks as one rule.
  typedef struct packed {
    logic [MASK_W-1:0] survive;
    logic [MASK_W-1:0] birth;
  } rule_t;

endpackage

// ===== rtl/core/llca_ram.sv =====
// Generic simple dual-port RAM with one write port and one registered read port.
module llca_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/core/llca_rule_unit.sv =====
// Shared rule unit: counts the live neighbors of one cell and applies the rule.
module llca_rule_unit (
  input  logic                 self_cell,
  input  logic [7:0]           nbrs,
  input  llca_pkg::rule_t      rule,
  output logic                 next_cell
);

  logic [llca_pkg::COUNT_W-1:0] count;

  always_comb begin
    count = '0;
    for (int i = 0; i < 8; i++) begin
      count = count + llca_pkg::COUNT_W'(nbrs[i]);
    end
  end

  // The count never exceeds eight, so it always falls inside the mask.
  assign next_cell = self_cell ? rule.survive[count] : rule.birth[count];

endmodule

// ===== rtl/core/life_like_cellular_automaton_step.sv =====
// Top level of the life-like cellular automaton: control, window registers and grid memory.
//
// The block holds a grid of one-bit cells in a row-wide memory. Each input word on the
// item channel (item_valid / item_stall) carries a command: write one cell, read one
// cell, or advance the whole grid one generation. Every command returns exactly one word
// on the result channel (result_valid / result_stall) with the cell read back (zero for
// other commands) and an echo of the command. Config writes (cfg_write, cfg_index, cfg_data)
// act at once; the user must make them while the block is idle, which it does not enforce.
//
// After reset the block clears the grid memory one row per cycle; item_stall stays high
// meanwhile. The block then works on one command at a time and holds item_stall high
// until that command's result is loaded into the output register, so the next word can
// be taken while the result still waits to be read. A write or read inside the grid
// passes from acceptance through a modify or bit-select state to the response state,
// which loads the result register; one outside the grid skips to the response state.
// An advance sweeps rows in use one at a time: a three-row window is loaded, and one
// shared rule unit walks all MAX_COLS columns of the window, one column per cycle.
// Each finished row is written back at once; the old rows stay in the window registers.
// While the receiver stalls, the result register holds its word and a finished command
// waits in its response state, keeping item_stall high.
module life_like_cellular_automaton_step #(
  parameter int MAX_ROWS = llca_pkg::MAX_ROWS_DEFAULT,
  parameter int MAX_COLS = llca_pkg::MAX_COLS_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  logic [llca_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [llca_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                             item_valid,
  output logic                             item_stall,
  input  logic [llca_pkg::CMD_W-1:0]       cmd,
  input  logic [llca_pkg::ROW_W-1:0]       row,
  input  logic [llca_pkg::COL_W-1:0]       col,
  input  logic                             cell_in,
  output logic                             result_valid,
  input  logic                             result_stall,
  output logic                             cell_value,
  output logic [llca_pkg::CMD_W-1:0]       answered_cmd
);

  localparam int RAW     = $clog2(MAX_ROWS);
  localparam int CIW     = $clog2(MAX_COLS);
  localparam int ROW_CAP = (MAX_ROWS < 127) ? MAX_ROWS : 127;
  localparam int COL_CAP = (MAX_COLS < 127) ? MAX_COLS : 127;
  localparam int CMPW    = ((CIW > llca_pkg::DIM_W) ? CIW : llca_pkg::DIM_W) + 1;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WR_MOD,
    ST_RD_SEL,
    ST_ADV_LD0,
    ST_ADV_LD1,
    ST_ADV_COL,
    ST_ADV_ROW,
    ST_ADV_NX,
    ST_RESP
  } state_t;

  state_t state;

  // Configuration registers.
  logic [llca_pkg::MASK_W-1:0] survive_mask;
  logic [llca_pkg::MASK_W-1:0] birth_mask;
  logic [llca_pkg::DIM_W-1:0]  rows_in_use;
  logic [llca_pkg::DIM_W-1:0]  cols_in_use;

  always_ff @(posedge clk) begin
    if (rst) begin
      survive_mask <= llca_pkg::SURVIVE_RESET;
      birth_mask   <= llca_pkg::BIRTH_RESET;
      rows_in_use  <= llca_pkg::ROWS_RESET;
      cols_in_use  <= llca_pkg::COLS_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        llca_pkg::REG_SURVIVE: survive_mask <= cfg_data;
        llca_pkg::REG_BIRTH:   birth_mask   <= cfg_data;
        llca_pkg::REG_ROWS:    rows_in_use  <= cfg_data[llca_pkg::DIM_W-1:0];
        llca_pkg::REG_COLS:    cols_in_use  <= cfg_data[llca_pkg::DIM_W-1:0];
        default: ;
      endcase
    end
  end

  // Sizes larger than the grid capacity act as the capacity.
  logic [llca_pkg::DIM_W-1:0] eff_rows;
  logic [llca_pkg::DIM_W-1:0] eff_cols;

  assign eff_rows = (rows_in_use > llca_pkg::DIM_W'(ROW_CAP)) ?
                    llca_pkg::DIM_W'(ROW_CAP) : rows_in_use;
  assign eff_cols = (cols_in_use > llca_pkg::DIM_W'(COL_CAP)) ?
                    llca_pkg::DIM_W'(COL_CAP) : cols_in_use;

  // Latched command.
  logic [llca_pkg::CMD_W-1:0] cmd_q;
  logic [RAW-1:0]             row_addr_q;
  logic [CIW-1:0]             col_idx_q;
  logic                       cell_q;
  logic                       pend_cell;

  // Sweep state.
  logic [RAW-1:0]             clr_addr;
  logic [llca_pkg::DIM_W-1:0] adv_row;
  logic [CIW-1:0]             col_cnt;
  logic                       nxt_fetch;
  logic [MAX_COLS-1:0]        win_prev;
  logic [MAX_COLS-1:0]        win_cur;
  logic [MAX_COLS-1:0]        win_nxt;
  logic [2:0]                 hist;
  logic [MAX_COLS-1:0]        next_gen_row;

  // Memory port signals.
  logic                mem_we;
  logic [RAW-1:0]      mem_waddr;
  logic [MAX_COLS-1:0] mem_wdata;
  logic                mem_re;
  logic [RAW-1:0]      mem_raddr;
  logic [MAX_COLS-1:0] rd_data;
  logic [MAX_COLS-1:0] patched_row;

  logic accept;
  logic in_grid;
  logic row_fetch_ok;
  logic last_row;
  logic col_live;
  logic right_ok;
  logic [7:0] nbrs;
  logic rule_next;
  logic new_bit;
  llca_pkg::rule_t rule;

  assign item_stall = (state != ST_IDLE);
  assign accept     = item_valid && !item_stall;
  assign in_grid    = ({1'b0, row} < eff_rows) && ({1'b0, col} < eff_cols);

  // Row r + 2 is fetched only while it is still inside the grid in use.
  assign row_fetch_ok = ({1'b0, adv_row} + 8'd2) < {1'b0, eff_rows};
  assign last_row     = ({1'b0, adv_row} + 8'd1) == {1'b0, eff_rows};

  always_comb begin
    for (int i = 0; i < MAX_COLS; i++) begin
      patched_row[i] = (col_idx_q == CIW'(i)) ? cell_q : rd_data[i];
    end
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = row_addr_q;
    mem_wdata = patched_row;
    mem_re    = 1'b0;
    mem_raddr = RAW'(adv_row + 7'd2);
    case (state)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr;
        mem_wdata = '0;
      end
      ST_IDLE: begin
        if (cmd == llca_pkg::CMD_ADVANCE) begin
          mem_re    = accept;
          mem_raddr = '0;
        end else begin
          mem_re    = accept && in_grid &&
                      (cmd == llca_pkg::CMD_WRITE || cmd == llca_pkg::CMD_READ);
          mem_raddr = RAW'(row);
        end
      end
      ST_WR_MOD: begin
        mem_we = 1'b1;
      end
      ST_ADV_LD0: begin
        mem_re    = (eff_rows > 7'd1);
        mem_raddr = RAW'(7'd1);
      end
      ST_ADV_ROW: begin
        mem_we    = 1'b1;
        mem_waddr = RAW'(adv_row);
        mem_wdata = next_gen_row;
        mem_re    = row_fetch_ok;
      end
      default: ;
    endcase
  end

  llca_ram #(
    .WIDTH (MAX_COLS),
    .DEPTH (MAX_ROWS)
  ) u_cell_store (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_waddr),
    .wr_data (mem_wdata),
    .rd_en   (mem_re),
    .rd_addr (mem_raddr),
    .rd_data (rd_data)
  );

  // Column window: bit 0 of each window register is the current column, bit 1 the one to
  // its right, and hist holds the column to its left. The right column counts only while
  // it is inside the grid in use; columns outside keep their old value.
  assign col_live = CMPW'(col_cnt) < CMPW'(eff_cols);
  assign right_ok = (CMPW'(col_cnt) + CMPW'(1)) < CMPW'(eff_cols);
  assign nbrs     = {hist,
                     win_prev[0], win_nxt[0],
                     right_ok & win_prev[1], right_ok & win_cur[1], right_ok & win_nxt[1]};
  assign rule     = '{survive: survive_mask, birth: birth_mask};

  llca_rule_unit u_rule (
    .self_cell (win_cur[0]),
    .nbrs      (nbrs),
    .rule      (rule),
    .next_cell (rule_next)
  );

  assign new_bit = col_live ? rule_next : win_cur[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_CLEAR;
      clr_addr     <= '0;
      result_valid <= 1'b0;
    end else begin
      // The response state reloads the register itself when the old word drains.
      if (result_valid && !result_stall && state != ST_RESP) begin
        result_valid <= 1'b0;
      end
      case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + RAW'(1);
          if (clr_addr == RAW'(MAX_ROWS - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            cmd_q      <= cmd;
            row_addr_q <= RAW'(row);
            col_idx_q  <= CIW'(col);
            cell_q     <= cell_in;
            pend_cell  <= 1'b0;
            adv_row    <= '0;
            case (cmd)
              llca_pkg::CMD_WRITE:   state <= in_grid ? ST_WR_MOD : ST_RESP;
              llca_pkg::CMD_READ:    state <= in_grid ? ST_RD_SEL : ST_RESP;
              llca_pkg::CMD_ADVANCE: state <= (eff_rows != '0) ? ST_ADV_LD0 : ST_RESP;
              default:               state <= ST_RESP;
            endcase
          end
        end
        ST_WR_MOD: begin
          state <= ST_RESP;
        end
        ST_RD_SEL: begin
          pend_cell <= rd_data[col_idx_q];
          state     <= ST_RESP;
        end
        ST_ADV_LD0: begin
          win_cur   <= rd_data;
          nxt_fetch <= (eff_rows > 7'd1);
          state     <= ST_ADV_LD1;
        end
        ST_ADV_LD1: begin
          win_nxt  <= nxt_fetch ? rd_data : '0;
          win_prev <= '0;
          col_cnt  <= '0;
          hist     <= '0;
          state    <= ST_ADV_COL;
        end
        ST_ADV_COL: begin
          next_gen_row <= {new_bit, next_gen_row[MAX_COLS-1:1]};
          win_prev     <= {win_prev[0], win_prev[MAX_COLS-1:1]};
          win_cur      <= {win_cur[0], win_cur[MAX_COLS-1:1]};
          win_nxt      <= {win_nxt[0], win_nxt[MAX_COLS-1:1]};
          hist         <= {win_prev[0], win_cur[0], win_nxt[0]};
          col_cnt      <= col_cnt + CIW'(1);
          if (col_cnt == CIW'(MAX_COLS - 1)) begin
            state <= ST_ADV_ROW;
          end
        end
        ST_ADV_ROW: begin
          win_prev  <= win_cur;
          win_cur   <= win_nxt;
          adv_row   <= adv_row + 7'd1;
          nxt_fetch <= row_fetch_ok;
          state     <= last_row ? ST_RESP : ST_ADV_NX;
        end
        ST_ADV_NX: begin
          win_nxt <= nxt_fetch ? rd_data : '0;
          col_cnt <= '0;
          hist    <= '0;
          state   <= ST_ADV_COL;
        end
        ST_RESP: begin
          if (!result_valid || !result_stall) begin
            result_valid <= 1'b1;
            cell_value   <= pend_cell;
            answered_cmd <= cmd_q;
            state        <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // A result word only appears when a command finishes.
  a_result_from_resp: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(state == ST_RESP))
    else $error("result word loaded outside the response state");

  // A finished command waits while the output register still holds an untaken word.
  a_resp_waits: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RESP && result_valid && result_stall) |=> (state == ST_RESP && result_valid))
    else $error("result register overwritten while stalled");

  // Every written-back generation row lies inside the grid in use.
  a_row_in_grid: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ADV_ROW) |-> (adv_row < eff_rows))
    else $error("advance wrote a row outside the grid in use");

  // The cell write-back directly follows the row read issued at acceptance.
  a_rmw_order: assert property (@(posedge clk) disable iff (rst)
    (state == ST_WR_MOD) |-> $past(accept && cmd == llca_pkg::CMD_WRITE))
    else $error("cell write-back without a preceding accepted write");

endmodule
